FILE: hdl/p_square_quantile_estimator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quantile estimator checker
// ---------------------------------------------------------------------------
`ifndef P_SQUARE_QUANTILE_ESTIMATOR_TOP_ASSERT_SVH
`define P_SQUARE_QUANTILE_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define PSQE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psqe check failed");

// next-cycle implication, held off during reset
`define PSQE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psqe check failed");

`endif

FILE: hdl/psqe_pkg.sv
// ---------------------------------------------------------------------------
// psqe_pkg
// Shared types and constants of the P-square quantile estimator.
// ---------------------------------------------------------------------------
package psqe_pkg;

    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 32;
    localparam int MARKERS  = 5;
    localparam int CFG_W    = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } psqe_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] estimate;
        logic                       ready_res;
        logic                       count_full;
    } psqe_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } psqe_div_stat_t;

endpackage

FILE: hdl/psqe_div.sv
// ---------------------------------------------------------------------------
// psqe_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module psqe_div #(
    parameter int N = 32,
    parameter int D = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [N-1:0]            dividend,
    input  logic [D-1:0]            divisor,
    output logic [N-1:0]            quotient,
    output psqe_pkg::psqe_div_stat_t stat
);
    import psqe_pkg::*;

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D-1:0]     rem_reg, rem_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [D-1:0]     dsr_reg, dsr_next;
    logic [D:0]       trial;
    logic             take;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        trial    = {rem_reg, quo_reg[N-1]};
        take     = (trial >= {1'b0, dsr_reg});
        if (start)
        begin
            cnt_next = CNT_W'(N);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = take ? D'(trial - {1'b0, dsr_reg}) : trial[D-1:0];
            quo_next = {quo_reg[N-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = (cnt_reg == CNT_W'(1));

endmodule

FILE: hdl/p_square_quantile_estimator_top.sv
// ---------------------------------------------------------------------------
// p_square_quantile_estimator_top
// Running quantile estimate over five P-square markers, linear moves only.
// ---------------------------------------------------------------------------
//  channel  | signals                              | role
//  sample   | sample_valid, sample_stall, beat     | op and Q16.16 sample in
//  result   | result_valid, result_stall, beat     | estimate and flags out
//  cfg      | cfg_we, cfg_wdata                    | quantile fraction write
//
//  A clear and a warm-up sample go straight to the finish step; the fifth sample
//  first runs a 16-step sort. A later sample is placed, then each inner marker is
//  multiplied and decided, and a marker that moves runs the serial divider and an apply.
//  sample_stall is high from acceptance until the result is loaded.
//  A held result stalls the next item only at its finish step.
//  Reset clears markers, positions and count; the fraction returns to 32768.
// ---------------------------------------------------------------------------
module p_square_quantile_estimator_top #(
    parameter int COUNT_WIDTH            = 32,
    parameter int QUANTILE_FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  psqe_pkg::psqe_in_t          sample_beat,
    output logic                        result_valid,
    input  logic                        result_stall,
    output psqe_pkg::psqe_out_t         result_beat,
    input  logic                        cfg_we,
    input  logic [psqe_pkg::CFG_W-1:0]  cfg_wdata
);
    import psqe_pkg::*;

    localparam int CW   = COUNT_WIDTH;
    localparam int QB   = QUANTILE_FRACTION_BITS;
    localparam int IW   = QB + 2;
    localparam int PW   = CW + IW;
    localparam int HW   = POS_W + QB + 3;
    localparam int CMPW = ((PW > HW) ? PW : HW) + 1;
    localparam int SW   = SAMPLE_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SORT   = 4'd1;
    localparam logic [3:0] S_PLACE  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_APPLY  = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    localparam logic [QB+CFG_W-1:0] QF_RESET_W = (QB + CFG_W)'(32768);

    logic [3:0]           state_reg, state_next;
    logic [QB-1:0]        qf_reg;
    logic signed [SW-1:0] h_reg [MARKERS];
    logic signed [SW-1:0] h_next [MARKERS];
    logic [POS_W-1:0]     p_reg [MARKERS];
    logic [POS_W-1:0]     p_next [MARKERS];
    logic [CW-1:0]        count_reg, count_next;
    logic signed [SW-1:0] x_reg, x_next;
    logic [3:0]           step_reg, step_next;
    logic [1:0]           mi_reg, mi_next;
    logic [CMPW-1:0]      want_reg, want_next;
    logic                 up_reg, up_next;
    logic                 ge_reg, ge_next;
    logic                 out_valid_reg, out_valid_next;
    psqe_out_t            out_reg, out_next;

    logic                 div_start;
    logic [SW-1:0]        div_dividend;
    logic [POS_W-1:0]     div_divisor;
    logic [SW-1:0]        div_quotient;
    psqe_div_stat_t       div_stat;

    logic [CW-1:0]        cnt_new;
    logic [2:0]           kk;
    logic                 found;
    logic [QB-1:0]        qf_eff;
    logic [IW-1:0]        inc_sel;
    logic [PW-1:0]        prod;
    logic [POS_W-1:0]     lo, pos, hi;
    logic signed [SW-1:0] ha, hl, hh, hb;
    logic [CMPW-1:0]      here, two_scale;
    logic                 go_down, go_up;
    logic signed [SW:0]   dpos, dneg;
    logic [CW-1:0]        cnt_m1;

    psqe_div #(
        .N (SW),
        .D (POS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // marker-indexed selections
    always_comb
    begin
        qf_eff = (qf_reg == '0) ? (QB'(1) << (QB - 1)) : qf_reg;
        unique case (mi_reg)
            2'd1:
            begin
                inc_sel = IW'(qf_eff);
                lo = p_reg[0]; pos = p_reg[1]; hi = p_reg[2];
                hl = h_reg[0]; ha = h_reg[1]; hh = h_reg[2];
            end
            2'd2:
            begin
                inc_sel = IW'(qf_eff) << 1;
                lo = p_reg[1]; pos = p_reg[2]; hi = p_reg[3];
                hl = h_reg[1]; ha = h_reg[2]; hh = h_reg[3];
            end
            2'd3:
            begin
                inc_sel = (IW'(1) << QB) + IW'(qf_eff);
                lo = p_reg[2]; pos = p_reg[3]; hi = p_reg[4];
                hl = h_reg[2]; ha = h_reg[3]; hh = h_reg[4];
            end
            default:
            begin
                inc_sel = '0;
                lo = '0; pos = '0; hi = '0;
                hl = '0; ha = '0; hh = '0;
            end
        endcase
        cnt_m1    = count_reg - CW'(1);
        prod      = PW'(cnt_m1) * PW'(inc_sel);
        here      = CMPW'(pos) << (QB + 1);
        two_scale = CMPW'(1) << (QB + 2);
        go_down   = ((want_reg + two_scale) <= here) &&
                    ({1'b0, pos} > ({1'b0, lo} + (POS_W + 1)'(1)));
        go_up     = (want_reg >= here) &&
                    ({1'b0, hi} > ({1'b0, pos} + (POS_W + 1)'(1)));
        hb        = go_down ? hl : hh;
        dpos      = {hb[SW-1], hb} - {ha[SW-1], ha};
        dneg      = {ha[SW-1], ha} - {hb[SW-1], hb};
    end

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        x_next         = x_reg;
        step_next      = step_reg;
        mi_next        = mi_reg;
        want_next      = want_reg;
        up_next        = up_reg;
        ge_next        = ge_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        div_start      = 1'b0;
        div_dividend   = (hb >= ha) ? dpos[SW-1:0] : dneg[SW-1:0];
        div_divisor    = go_down ? (pos - lo) : (hi - pos);
        cnt_new        = (count_reg == '1) ? count_reg : count_reg + CW'(1);
        kk             = 3'(MARKERS);
        found          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next = sample_beat.sample;
                    if (sample_beat.op == OP_CLEAR)
                    begin
                        for (int i = 0; i < MARKERS; i++)
                        begin
                            h_next[i] = '0;
                            p_next[i] = '0;
                        end
                        count_next = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        count_next = cnt_new;
                        if (cnt_new <= CW'(MARKERS))
                        begin
                            for (int i = 0; i < MARKERS; i++)
                                if (cnt_new[2:0] == 3'(i + 1))
                                    h_next[i] = sample_beat.sample;
                            step_next  = '0;
                            state_next = (cnt_new == CW'(MARKERS)) ? S_SORT : S_FINISH;
                        end
                        else
                            state_next = S_PLACE;
                    end
                end
            end
            S_SORT:
            begin
                // bubble sort: four passes of four compare-swap steps
                for (int m = 0; m < MARKERS - 1; m++)
                    if (step_reg[1:0] == 2'(m) && h_reg[m] > h_reg[m+1])
                    begin
                        h_next[m]   = h_reg[m+1];
                        h_next[m+1] = h_reg[m];
                    end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    for (int i = 0; i < MARKERS; i++)
                        p_next[i] = POS_W'(i + 1);
                    state_next = S_FINISH;
                end
            end
            S_PLACE:
            begin
                for (int i = 0; i < MARKERS; i++)
                    if (!found && h_reg[i] > x_reg)
                    begin
                        kk    = 3'(i);
                        found = 1'b1;
                    end
                for (int i = 0; i < MARKERS; i++)
                    if (3'(i) >= kk && p_reg[i] != '1)
                        p_next[i] = p_reg[i] + POS_W'(1);
                if (kk == 3'd0)
                begin
                    h_next[0] = x_reg;
                    p_next[0] = POS_W'(1);
                end
                else if (kk == 3'(MARKERS))
                    h_next[MARKERS-1] = x_reg;
                mi_next    = 2'd1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                want_next  = CMPW'(prod);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (go_down || go_up)
                begin
                    div_start  = 1'b1;
                    up_next    = !go_down;
                    ge_next    = (hb >= ha);
                    state_next = S_DIV;
                end
                else if (mi_reg == 2'd3)
                    state_next = S_FINISH;
                else
                begin
                    mi_next    = mi_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                for (int i = 1; i < MARKERS - 1; i++)
                    if (mi_reg == 2'(i))
                    begin
                        h_next[i] = ge_reg ? SW'(ha + div_quotient) : SW'(ha - div_quotient);
                        p_next[i] = up_reg ? pos + POS_W'(1) : pos - POS_W'(1);
                    end
                if (mi_reg == 2'd3)
                    state_next = S_FINISH;
                else
                begin
                    mi_next    = mi_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_FINISH:
            begin
                // load only once the previous result has left
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.estimate   = h_reg[2];
                    out_next.ready_res  = (count_reg >= CW'(MARKERS));
                    out_next.count_full = (count_reg == '1);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qf_reg        <= QF_RESET_W[QB-1:0];
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MARKERS; i++)
            begin
                h_reg[i] <= '0;
                p_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
            p_reg         <= p_next;
            if (cfg_we)
                qf_reg <= QB'({{QB{1'b0}}, cfg_wdata});
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        step_reg <= step_next;
        mi_reg   <= mi_next;
        want_reg <= want_next;
        up_reg   <= up_next;
        ge_reg   <= ge_next;
        out_reg  <= out_next;
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result_beat  = out_reg;

endmodule

FILE: hdl/psqe_checker.sv
// ---------------------------------------------------------------------------
// psqe_checker
// Port-level checks on the quantile estimator, bound to the top level.
// ---------------------------------------------------------------------------
`include "p_square_quantile_estimator_top_assert.svh"

module psqe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_stall,
    input logic                result_valid,
    input logic                result_stall,
    input psqe_pkg::psqe_out_t result_beat
);
    import psqe_pkg::*;

    // a held result beat keeps its value
    `PSQE_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result_beat))
    // an accepted beat keeps the input stalled while it is worked on
    `PSQE_ASSERT_NEXT(a_busy, sample_valid && !sample_stall, sample_stall)
    // a saturated count implies warm-up is over
    `PSQE_ASSERT_NOW(a_full, result_valid && result_beat.count_full, result_beat.ready_res)
    // a new result appears only as the input reopens
    `PSQE_ASSERT_NOW(a_load, $rose(result_valid), !sample_stall)

endmodule

bind p_square_quantile_estimator_top psqe_checker u_psqe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
);
